### rtl/core/rzct_pkg.sv
// ============================================================================
// rzct_pkg: shared constants and types of the rising zero-crossing timer
// Field widths, stream packing and the request/response records of the
// shared divider.
// ============================================================================
`default_nettype none

package rzct_pkg;

  // Field widths of the sample stream.
  localparam int SAMPLE_BITS = 16;
  localparam int TIME_BITS   = 32;
  localparam int CHAN_BITS   = 4;

  // Configuration register and result index.
  localparam int UNIT_BITS  = 32;
  localparam int INDEX_BITS = 32;

  // Stream packing. Input tdata: sample, then sample_time. Input tuser:
  // channel_start, then channel_id. Output tdata: crossing_index. Output
  // tuser: crossing_channel.
  localparam int S_DATA_BITS = ((SAMPLE_BITS + TIME_BITS + 7) / 8) * 8;
  localparam int S_USER_BITS = 1 + CHAN_BITS;
  localparam int M_DATA_BITS = ((INDEX_BITS + 7) / 8) * 8;
  localparam int M_USER_BITS = CHAN_BITS;

  // Datapath widths. The product of a time step and a sample magnitude is
  // the dividend of the interpolation. Quotients never exceed TIME_BITS, so
  // the divider produces TIME_BITS quotient bits rounded up to an even
  // count, two bits per cycle.
  localparam int PROD_BITS  = TIME_BITS + SAMPLE_BITS;
  localparam int DVS_BITS   = (SAMPLE_BITS > UNIT_BITS) ? SAMPLE_BITS : UNIT_BITS;
  localparam int QUO_BITS   = TIME_BITS + (TIME_BITS % 2);
  localparam int STEP_COUNT = QUO_BITS / 2;
  localparam int CNT_BITS   = $clog2(STEP_COUNT + 1);

  // Request to the divider. The dividend is rem_init * 2^QUO_BITS + low,
  // with rem_init below the divisor.
  typedef struct packed {
    logic                start;
    logic [DVS_BITS-1:0] rem_init;
    logic [QUO_BITS-1:0] low;
    logic [DVS_BITS-1:0] divisor;
  } div_req_t;

  // Response of the divider. done pulses for one cycle with quotient valid.
  typedef struct packed {
    logic                busy;
    logic                done;
    logic [QUO_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

### rtl/core/rzct_divider.sv
// ============================================================================
// rzct_divider: iterative restoring divider, two quotient bits per cycle
// Shared by the interpolation step and the time-unit scaling.
// ============================================================================
`default_nettype none

module rzct_divider (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rzct_pkg::div_req_t req,
  output rzct_pkg::div_rsp_t      rsp
);
  import rzct_pkg::*;

  logic                busy;
  logic                done;
  logic [CNT_BITS-1:0] count;
  logic [DVS_BITS-1:0] rem;
  logic [QUO_BITS-1:0] low;
  logic [DVS_BITS-1:0] divisor;

  logic [DVS_BITS:0]   trial1;
  logic [DVS_BITS:0]   trial2;
  logic [DVS_BITS-1:0] rem1;
  logic [DVS_BITS-1:0] rem_next;
  logic                bit1;
  logic                bit2;

  // Two dependent restoring steps per cycle. A zero divisor gives all ones.
  always_comb begin
    trial1   = {rem, low[QUO_BITS-1]};
    bit1     = (trial1 >= {1'b0, divisor});
    rem1     = bit1 ? DVS_BITS'(trial1 - {1'b0, divisor}) : DVS_BITS'(trial1);
    trial2   = {rem1, low[QUO_BITS-2]};
    bit2     = (trial2 >= {1'b0, divisor});
    rem_next = bit2 ? DVS_BITS'(trial2 - {1'b0, divisor}) : DVS_BITS'(trial2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= CNT_BITS'(STEP_COUNT);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operand registers; the quotient bits shift into the low word.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem     <= req.rem_init;
      low     <= req.low;
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      low <= {low[QUO_BITS-3:0], bit1, bit2};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = low;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider started while busy");

  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    req.start |=> busy && count == CNT_BITS'(STEP_COUNT))
    else $error("divider did not begin its step count");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) && !busy)
    else $error("divider done without a finished run");

  a_count_live: assert property (@(posedge clk) disable iff (rst)
    busy |-> count != '0)
    else $error("divider busy with an empty step count");

endmodule

`default_nettype wire

### rtl/core/rising_zero_crossing_timer_top.sv
// ============================================================================
// rising_zero_crossing_timer_top: interpolated rising zero-crossing timer
// Finds negative-to-positive sign changes in a sampled sonar signal and
// reports the linearly interpolated crossing time, scaled by a time unit.
// ============================================================================
//
//   Channel   Dir  Handshake          Word contents (low bit first)
//   s_axis    in   tvalid / tready    tdata: sample, sample_time
//                                     tuser: channel_start, channel_id
//   m_axis    out  tvalid / tready    tdata: crossing_index
//                                     tuser: crossing_channel
//   cfg       in   cfg_wen            cfg_wdata: time_unit
//
// A word that does not complete a crossing only updates the stored previous
// sample and time. A word that completes a crossing takes a multiply, a pass
// through the one shared divider, an add, a second divider pass (two quotient
// bits a step each time) and an output load. s_axis_tready is low while a
// word is being worked on. The result register lets a new word enter while
// a result waits on m_axis; a stalled result only holds the next crossing
// at its final load. rst is synchronous and active high; it clears the
// stored sample history, sets time_unit to one and empties the result
// register.
//
`default_nettype none

module rising_zero_crossing_timer_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // Configuration: time_unit, ticks per output index step.
  input  wire logic                             cfg_wen,
  input  wire logic [rzct_pkg::UNIT_BITS-1:0]   cfg_wdata,
  // Sample stream.
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata fields from bit 0: sample, sample_time.
  input  wire logic [rzct_pkg::S_DATA_BITS-1:0] s_axis_tdata,
  // tuser fields from bit 0: channel_start, channel_id.
  input  wire logic [rzct_pkg::S_USER_BITS-1:0] s_axis_tuser,
  // Crossing stream.
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // tdata fields from bit 0: crossing_index.
  output logic [rzct_pkg::M_DATA_BITS-1:0]      m_axis_tdata,
  // tuser fields from bit 0: crossing_channel.
  output logic [rzct_pkg::M_USER_BITS-1:0]      m_axis_tuser
);
  import rzct_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV1,
    S_WAIT1,
    S_ADD,
    S_DIV2,
    S_WAIT2,
    S_EMIT
  } state_t;

  state_t state;

  // Unpacked input fields.
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic [TIME_BITS-1:0]          in_time;
  logic                          in_start;
  logic [CHAN_BITS-1:0]          in_chan;
  logic                          accept;
  logic                          crossing;

  assign in_sample = s_axis_tdata[SAMPLE_BITS-1:0];
  assign in_time   = s_axis_tdata[SAMPLE_BITS +: TIME_BITS];
  assign in_start  = s_axis_tuser[0];
  assign in_chan   = s_axis_tuser[1 +: CHAN_BITS];

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Configuration register.
  logic [UNIT_BITS-1:0] time_unit;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_unit <= UNIT_BITS'(1);
    end else if (cfg_wen) begin
      time_unit <= cfg_wdata;
    end
  end

  // Sample history. It is loaded by every accepted word.
  logic signed [SAMPLE_BITS-1:0] prev_sample;
  logic [TIME_BITS-1:0]          prev_time;
  logic                          prev_valid;

  // A crossing needs a stored sample that is strictly negative, followed by
  // a strictly positive one that is not a channel start.
  assign crossing = prev_valid && !in_start && (prev_sample < 0) && (in_sample > 0);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_sample <= '0;
      prev_time   <= '0;
      prev_valid  <= 1'b0;
    end else if (accept) begin
      prev_sample <= in_sample;
      prev_time   <= in_time;
      prev_valid  <= 1'b1;
    end
  end

  // Working registers of one crossing.
  logic signed [SAMPLE_BITS-1:0] base_sample;
  logic [TIME_BITS-1:0]          base_time;
  logic signed [SAMPLE_BITS-1:0] cur_sample;
  logic [TIME_BITS-1:0]          cur_time;
  logic [CHAN_BITS-1:0]          cur_chan;
  logic [PROD_BITS-1:0]          product;
  logic [SAMPLE_BITS-1:0]        span;
  logic [TIME_BITS-1:0]          cross_time;

  logic [TIME_BITS-1:0]          delta;
  logic [SAMPLE_BITS-1:0]        mag;
  logic [SAMPLE_BITS-1:0]        span_next;

  // The time step wraps modulo 2^TIME_BITS. The magnitude of the negative
  // sample fits SAMPLE_BITS unsigned, and so does the sample span.
  always_comb begin
    delta     = cur_time - base_time;
    mag       = SAMPLE_BITS'(-base_sample);
    span_next = SAMPLE_BITS'(cur_sample) + mag;
  end

  div_req_t div_req;
  div_rsp_t div_rsp;

  // First pass: time step times magnitude over span. The quotient stays
  // below the time step, so the bits above QUO_BITS are a valid initial
  // remainder. Second pass: crossing time over time_unit.
  always_comb begin
    div_req.start = (state == S_DIV1) || (state == S_DIV2);
    if (state == S_DIV1) begin
      div_req.rem_init = DVS_BITS'(product >> QUO_BITS);
      div_req.low      = QUO_BITS'(product);
      div_req.divisor  = DVS_BITS'(span);
    end else begin
      div_req.rem_init = '0;
      div_req.low      = QUO_BITS'(cross_time);
      div_req.divisor  = DVS_BITS'(time_unit);
    end
  end

  rzct_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      base_sample <= prev_sample;
      base_time   <= prev_time;
      cur_sample  <= in_sample;
      cur_time    <= in_time;
      cur_chan    <= in_chan;
    end
    if (state == S_MUL) begin
      product <= PROD_BITS'(delta) * PROD_BITS'(mag);
      span    <= span_next;
    end
    if (state == S_ADD) begin
      cross_time <= base_time + TIME_BITS'(div_rsp.quotient);
    end
  end

  // Scaled index; a zero time unit or a quotient beyond the index width
  // reads as all ones.
  logic                  index_sat;
  logic [INDEX_BITS-1:0] index_val;

  always_comb begin
    index_sat = (time_unit == '0) || ((div_rsp.quotient >> INDEX_BITS) != '0);
    index_val = index_sat ? '1 : INDEX_BITS'(div_rsp.quotient);
  end

  logic [INDEX_BITS-1:0] index_hold;
  logic                  emit_load;

  // The finished crossing moves into the result register once that register
  // is empty or is being read in the same cycle.
  assign emit_load = (state == S_EMIT) && (!m_axis_tvalid || m_axis_tready);

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (emit_load) begin
        m_axis_tvalid <= 1'b1;
        m_axis_tdata  <= M_DATA_BITS'(index_hold);
        m_axis_tuser  <= cur_chan;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && crossing) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_DIV1;
        end
        S_DIV1: begin
          state <= S_WAIT1;
        end
        S_WAIT1: begin
          if (div_rsp.done) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          state <= S_DIV2;
        end
        S_DIV2: begin
          state <= S_WAIT2;
        end
        S_WAIT2: begin
          if (div_rsp.done) begin
            index_hold <= index_val;
            state      <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### dv/testbench.sv
// ============================================================================
// testbench: self-checking bench for the rising zero-crossing timer
// Sends directed words, then channel bursts with random content plus noise,
// and checks every crossing word against an in-bench predictor of the
// interpolated crossing index, over several time_unit settings.
// ============================================================================
`default_nettype none

module testbench;

  import rzct_pkg::*;

  // Phases of random traffic, each with its own time_unit setting.
  localparam int PHASE_COUNT     = 7;
  localparam int WORDS_PER_PHASE = 136;
  // Cycles allowed after the last crossing before touching the register or
  // ending the run.
  localparam int SETTLE_CYCLES   = 60;
  // Length of the long receiver stall.
  localparam int HOLD_CYCLES     = 400;
  // Cycles with no accepted word on either side before the run is abandoned.
  localparam int WATCHDOG_LIMIT  = 4000;

  // One sample word as the stream carries it.
  typedef struct packed {
    logic [CHAN_BITS-1:0]          chan;
    logic                          first;
    logic [TIME_BITS-1:0]          stamp;
    logic signed [SAMPLE_BITS-1:0] sample;
  } sample_word_t;

  // One crossing word.
  typedef struct packed {
    logic [CHAN_BITS-1:0]  chan;
    logic [INDEX_BITS-1:0] index;
  } crossing_t;

  // Predicts crossing words from accepted sample words and checks the
  // crossing words that the block delivers, oldest first.
  class crossing_scoreboard;
    logic [UNIT_BITS-1:0]          unit;
    logic signed [SAMPLE_BITS-1:0] last_sample;
    logic [TIME_BITS-1:0]          last_stamp;
    bit                            have_last;
    crossing_t                     expected_q[$];
    int                            errors;

    function new();
      unit        = 1;
      last_sample = '0;
      last_stamp  = '0;
      have_last   = 1'b0;
      errors      = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_sample(sample_word_t w);
      logic [TIME_BITS-1:0] step;
      logic [TIME_BITS-1:0] cross_at;
      longint unsigned      delta, mag, span, frac;
      crossing_t            c;
      if (have_last && !w.first && last_sample < 0 && w.sample > 0) begin
        // The time step wraps at the timestamp width.
        step     = w.stamp - last_stamp;
        delta    = step;
        mag      = -longint'(last_sample);
        span     = longint'(w.sample) + mag;
        frac     = (delta * mag) / span;
        cross_at = last_stamp + frac;
        c.chan   = w.chan;
        c.index  = (unit == '0) ? '1 : cross_at / unit;
        expected_q.insert(expected_q.size(), c);
      end
      last_sample = w.sample;
      last_stamp  = w.stamp;
      have_last   = 1'b1;
    endfunction

    function void check_crossing(crossing_t got);
      crossing_t want;
      if (expected_q.size() == 0) begin
        $error("crossing word with none expected: channel %0d, index 0x%08h",
               got.chan, got.index);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.chan !== want.chan) begin
        $error("crossing_channel: expected %0d, got %0d", want.chan, got.chan);
        errors++;
      end
      if (got.index !== want.index) begin
        $error("crossing_index: expected 0x%08h, got 0x%08h", want.index, got.index);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wen = 1'b0;
  logic [UNIT_BITS-1:0]   cfg_wdata = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_DATA_BITS-1:0] s_axis_tdata = '0;
  logic [S_USER_BITS-1:0] s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_DATA_BITS-1:0] m_axis_tdata;
  logic [M_USER_BITS-1:0] m_axis_tuser;

  crossing_scoreboard sb;

  // Random idling on both sides; cleared for one phase to give a stretch of
  // back-to-back traffic.
  bit idle_on = 1'b1;
  // Asks the receiver for one long stall.
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  rising_zero_crossing_timer_top u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The bench drives every input at the rising edge, and the block changes its
  // outputs only there, so the handshake signals are stable at the falling
  // edge. A word seen valid and ready at the falling edge is accepted at the
  // next rising edge; this is where both streams are observed. The watchdog
  // counts falling edges with nothing accepted on either side.
  always @(negedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_sample(sample_word_t'({s_axis_tuser, s_axis_tdata}));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_crossing(crossing_t'({m_axis_tuser, m_axis_tdata[INDEX_BITS-1:0]}));
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Receiver: ready most of the time, with random gaps while idling is on.
  // On request it holds ready low for a long stretch, counted here, so that
  // the result register fills and the block backs up its sample input.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_axis_tready <= idle_on ? ($urandom_range(0, 99) >= 8) : 1'b1;
      end
    end
  end

  function automatic sample_word_t make_word(input int value, input logic [31:0] stamp,
                                             input bit first, input int chan);
    sample_word_t w;
    w.sample = SAMPLE_BITS'(value);
    w.stamp  = stamp;
    w.first  = first;
    w.chan   = CHAN_BITS'(chan);
    return w;
  endfunction

  // Sample of a burst: mostly alternating negative and positive so that
  // crossings are frequent, with full-scale values, ones, zeros and random
  // signs mixed in.
  function automatic logic signed [SAMPLE_BITS-1:0] burst_sample(input bit want_negative);
    int mag;
    case ($urandom_range(0, 9))
      0:       mag = want_negative ? 32768 : 32767;
      1:       mag = 1;
      default: mag = $urandom_range(1, 32767);
    endcase
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return SAMPLE_BITS'($urandom);
      2:       return want_negative ? SAMPLE_BITS'(mag) : SAMPLE_BITS'(-mag);
      default: return want_negative ? SAMPLE_BITS'(-mag) : SAMPLE_BITS'(mag);
    endcase
  endfunction

  // Offer one word and wait until it is accepted. Returns at the rising edge
  // of acceptance with tvalid still high, so the next word can follow at once.
  task automatic send_word(input sample_word_t w);
    bit ok;
    if (idle_on && $urandom_range(0, 99) < 8) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {w.stamp, w.sample};
    s_axis_tuser  <= {w.chan, w.first};
    do begin
      @(negedge clk);
      ok = s_axis_tready;
      @(posedge clk);
    end while (!ok);
  endtask

  // Bursts of one channel each: a channel start, then samples with a rising
  // timestamp and occasional backward steps and large jumps. About one draw
  // in ten sends a single word of pure noise instead of a burst.
  task automatic random_words(input int count);
    sample_word_t         w;
    logic [TIME_BITS-1:0] stamp;
    logic [CHAN_BITS-1:0] chan;
    int                   left, burst, i;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        w.sample = SAMPLE_BITS'($urandom);
        w.stamp  = $urandom;
        w.first  = 1'($urandom);
        w.chan   = CHAN_BITS'($urandom);
        send_word(w);
        left--;
      end else begin
        burst = $urandom_range(2, 12);
        chan  = CHAN_BITS'($urandom);
        stamp = $urandom_range(0, 1) ? $urandom : TIME_BITS'($urandom_range(0, 5000));
        for (i = 0; i < burst && left > 0; i++) begin
          case ($urandom_range(0, 19))
            0:       stamp = stamp - $urandom_range(1, 1000);
            1:       stamp = stamp + $urandom;
            2:       stamp = stamp;
            default: stamp = stamp + $urandom_range(1, 500);
          endcase
          w.sample = burst_sample(i % 2 == 0);
          w.stamp  = stamp;
          w.first  = (i == 0) || ($urandom_range(0, 29) == 0);
          w.chan   = chan;
          send_word(w);
          left--;
        end
      end
    end
  endtask

  // Stop offering, wait for every expected crossing, then give the block time
  // to finish any word still in its datapath.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Called only while the block is idle.
  task automatic write_unit(input logic [UNIT_BITS-1:0] value);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    sb.unit = value;
  endtask

  initial begin
    sample_word_t         directed_q[$];
    logic [UNIT_BITS-1:0] unit_plan [PHASE_COUNT];
    int                   p;

    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed words, with time_unit still at its reset value of one.
    // The first word after reset is negative; the next must cross.
    directed_q.insert(directed_q.size(), make_word(-100, 32'd1000, 1'b0, 3));
    directed_q.insert(directed_q.size(), make_word(100, 32'd1010, 1'b0, 3));
    // Full-scale swing over the whole timestamp range.
    directed_q.insert(directed_q.size(), make_word(-32768, 32'd0, 1'b1, 15));
    directed_q.insert(directed_q.size(), make_word(32767, 32'hFFFF_FFFF, 1'b0, 15));
    // Crossing whose interpolated time wraps past the top of the timestamp.
    directed_q.insert(directed_q.size(), make_word(-1, 32'hFFFF_FFF0, 1'b1, 0));
    directed_q.insert(directed_q.size(), make_word(1, 32'h0000_0020, 1'b0, 0));
    // Timestamp going backward across a crossing.
    directed_q.insert(directed_q.size(), make_word(-10, 32'd5000, 1'b0, 7));
    directed_q.insert(directed_q.size(), make_word(10, 32'd1000, 1'b0, 7));
    // A channel start on the positive sample suppresses the crossing.
    directed_q.insert(directed_q.size(), make_word(-50, 32'd2000, 1'b0, 9));
    directed_q.insert(directed_q.size(), make_word(50, 32'd2100, 1'b1, 9));
    // Passing through an exact zero is not a crossing.
    directed_q.insert(directed_q.size(), make_word(-10, 32'd3000, 1'b0, 9));
    directed_q.insert(directed_q.size(), make_word(0, 32'd3010, 1'b0, 9));
    directed_q.insert(directed_q.size(), make_word(10, 32'd3020, 1'b0, 9));
    // Smallest swing with no time step.
    directed_q.insert(directed_q.size(), make_word(-1, 32'd4000, 1'b0, 12));
    directed_q.insert(directed_q.size(), make_word(1, 32'd4000, 1'b0, 12));
    // A falling edge is ignored; the rise after it counts.
    directed_q.insert(directed_q.size(), make_word(32767, 32'd5000, 1'b0, 12));
    directed_q.insert(directed_q.size(), make_word(-32768, 32'd6000, 1'b0, 12));
    directed_q.insert(directed_q.size(), make_word(32767, 32'd6001, 1'b0, 5));
    foreach (directed_q[i]) send_word(directed_q[i]);
    settle();

    // Register settings: the largest unit, zero, small ones and random ones.
    unit_plan = '{32'hFFFF_FFFF, 32'd0, 32'd3, 32'd1, 32'd0, 32'd1000, 32'd0};
    unit_plan[4] = $urandom;
    unit_plan[6] = $urandom_range(1, 65535);

    for (p = 0; p < PHASE_COUNT; p++) begin
      write_unit(unit_plan[p]);
      // Phase two runs without any idling; phase one opens with a long
      // receiver stall while samples keep coming.
      idle_on = (p != 2);
      if (p == 1) hold_req = 1'b1;
      random_words(WORDS_PER_PHASE);
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### rising_zero_crossing_timer_top.f
rtl/core/rzct_pkg.sv
rtl/core/rzct_divider.sv
rtl/core/rising_zero_crossing_timer_top.sv
dv/testbench.sv
